[rtl/stable_priority_task_queue_top_defines.svh]
// Assertion helpers for the queue RTL, included by the controller.
`ifndef STABLE_PRIORITY_TASK_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_TASK_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define SPTQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define SPTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sptq_pkg.sv]
// ---------------------------------------------------------------------------
// sptq_pkg
// Types and constants of the stable priority task queue.
// ---------------------------------------------------------------------------
package sptq_pkg;

  localparam int unsigned CAPACITY      = 1024;
  localparam int unsigned PRIORITY_BITS = 16;
  localparam int unsigned HANDLE_BITS   = 16;
  localparam int unsigned ORDER_BITS    = 32;
  localparam int unsigned IDX_W         = $clog2(CAPACITY);
  localparam int unsigned CNT_W         = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_TAKE   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_STOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_STOPPED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_MOVE
  } state_e;

  typedef struct packed {
    op_e                             op;
    logic signed [PRIORITY_BITS-1:0] priority_req;
    logic [HANDLE_BITS-1:0]          task_handle;
  } req_t;

  typedef struct packed {
    status_e                         status;
    logic [HANDLE_BITS-1:0]          out_handle;
    logic signed [PRIORITY_BITS-1:0] out_priority;
    logic [CNT_W-1:0]                pending_count;
  } rsp_t;

  typedef struct packed {
    logic signed [PRIORITY_BITS-1:0] prio;
    logic [HANDLE_BITS-1:0]          handle;
    logic [ORDER_BITS-1:0]           order;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;   // request taken this cycle
    logic issue;    // read scan slot, advance scan index
    logic tail;     // read last occupied slot
    logic move;     // retire best slot, write response
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic take_short;  // take finishes at once (halted or empty)
    logic scan_last;   // scan index at last occupied slot
  } sts_t;

endpackage

[rtl/sptq_ram.sv]
// ---------------------------------------------------------------------------
// sptq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sptq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sptq_dp.sv]
// ---------------------------------------------------------------------------
// sptq_dp
// Entry store, counters, best-entry scan and response register.
// ---------------------------------------------------------------------------
module sptq_dp import sptq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output rsp_t rsp_o
);

  logic [CNT_W-1:0]      count_q, count_d;
  logic [ORDER_BITS-1:0] order_q, order_d;
  logic                  halted_q, halted_d;
  logic [IDX_W-1:0]      scan_idx_q, scan_idx_d;
  logic                  cmp_v_q, first_q;
  logic [IDX_W-1:0]      cmp_idx_q;
  entry_t                best_q;
  logic [IDX_W-1:0]      best_idx_q;
  rsp_t                  rsp_q, rsp_d;
  logic                  rsp_load;

  logic [IDX_W-1:0]      last_idx;
  logic                  we;
  logic [IDX_W-1:0]      waddr, raddr;
  entry_t                wdata, rdata, new_entry;
  logic [ORDER_BITS-1:0] order_diff;
  logic                  cand_wins;
  logic [CNT_W-1:0]      count_dec;

  assign last_idx  = IDX_W'(count_q - 1'b1);
  assign count_dec = count_q - 1'b1;

  assign new_entry.prio   = req_i.priority_req;
  assign new_entry.handle = req_i.task_handle;
  assign new_entry.order  = order_q;

  // Packed store: slots 0 .. count-1 hold entries; a take fills its hole
  // with the last entry.
  always_comb begin
    we    = 1'b0;
    waddr = best_idx_q;
    wdata = rdata;
    if (cmd_i.move) begin
      we = 1'b1;
    end else if (cmd_i.accept && req_i.op == OP_SUBMIT && !halted_q &&
                 count_q != CNT_W'(CAPACITY)) begin
      we    = 1'b1;
      waddr = IDX_W'(count_q);
      wdata = new_entry;
    end
  end

  assign raddr = cmd_i.tail ? last_idx : scan_idx_q;

  sptq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign order_diff = rdata.order - best_q.order;
  assign cand_wins  = first_q || (rdata.prio < best_q.prio) ||
                      (rdata.prio == best_q.prio && order_diff[ORDER_BITS-1]);

  assign sts_o.take_short = halted_q || count_q == '0;
  assign sts_o.scan_last  = scan_idx_q == last_idx;

  always_comb begin
    count_d    = count_q;
    order_d    = order_q;
    halted_d   = halted_q;
    scan_idx_d = scan_idx_q;
    rsp_load   = 1'b0;
    rsp_d      = rsp_q;
    if (cmd_i.issue) begin
      scan_idx_d = scan_idx_q + 1'b1;
    end
    if (cmd_i.move) begin
      count_d              = count_dec;
      rsp_load             = 1'b1;
      rsp_d.status         = ST_OK;
      rsp_d.out_handle     = best_q.handle;
      rsp_d.out_priority   = best_q.prio;
      rsp_d.pending_count  = count_dec;
    end else if (cmd_i.accept) begin
      rsp_load           = 1'b1;
      rsp_d.status       = ST_OK;
      rsp_d.out_handle   = '0;
      rsp_d.out_priority = '0;
      scan_idx_d         = '0;
      case (req_i.op)
        OP_SUBMIT: begin
          if (halted_q) begin
            rsp_d.status = ST_STOPPED;
          end else if (count_q == CNT_W'(CAPACITY)) begin
            rsp_d.status = ST_FULL;
          end else begin
            count_d = count_q + 1'b1;
            order_d = order_q + 1'b1;
          end
        end
        OP_TAKE: begin
          rsp_d.status = halted_q ? ST_STOPPED : ST_EMPTY;
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        OP_STOP: begin
          count_d  = '0;
          halted_d = 1'b1;
        end
        default: begin
          count_d = count_q;
        end
      endcase
      rsp_d.pending_count = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      order_q    <= '0;
      halted_q   <= 1'b0;
      scan_idx_q <= '0;
      cmp_v_q    <= 1'b0;
    end else begin
      count_q    <= count_d;
      order_q    <= order_d;
      halted_q   <= halted_d;
      scan_idx_q <= scan_idx_d;
      cmp_v_q    <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= scan_idx_q;
    first_q   <= scan_idx_q == '0;
    if (cmp_v_q && cand_wins) begin
      best_q     <= rdata;
      best_idx_q <= cmp_idx_q;
    end
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

[rtl/sptq_ctrl.sv]
// ---------------------------------------------------------------------------
// sptq_ctrl
// Sequencer for requests, take scans and the response handshake.
// ---------------------------------------------------------------------------
`include "stable_priority_task_queue_top_defines.svh"

module sptq_ctrl import sptq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  op_e  op_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, long_take;

  assign in_ready_o = state_q == S_IDLE && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign long_take  = accept && op_i == OP_TAKE && !sts_i.take_short;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (long_take) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        state_d = S_MOVE;
      end
      S_MOVE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.accept = accept;
    cmd_o.issue  = state_q == S_SCAN;
    cmd_o.tail   = state_q == S_TAIL;
    cmd_o.move   = state_q == S_MOVE;
    out_valid_d  = out_valid_q && !out_ready_i;
    if ((accept && !long_take) || state_q == S_MOVE) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SPTQ_ASSERT_NOW(a_busy_no_ready, state_q != S_IDLE, !in_ready_o, "ready while busy")
  `SPTQ_ASSERT_NEXT(a_scan_to_tail, state_q == S_SCAN && sts_i.scan_last,
                    state_q == S_TAIL, "scan did not end")
  `SPTQ_ASSERT_NEXT(a_move_fills, state_q == S_MOVE, out_valid_q, "take lost its response")

endmodule

[rtl/stable_priority_task_queue_top.sv]
// ---------------------------------------------------------------------------
// stable_priority_task_queue_top
// Bounded priority queue of task handles, lowest priority served first,
// oldest first among equal priorities.
// ---------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_ready_o | req_t  (op, priority, handle)
//  out     | output    | out_valid_o/out_ready_i | rsp_t  (status, handle, prio, count)
//
// Submit, clear, stop and a take that is refused are answered from the accept, without a scan.
// A successful take runs through the accept, one RAM read per stored
// entry through the single read port, then a read of the last entry and
// a write that moves it into the freed slot.
// Reset clears counters, stopped flag and control; entry RAM needs no clear.
// A new request is taken while the previous response waits, provided the
// response register frees in the same cycle.
// ---------------------------------------------------------------------------
module stable_priority_task_queue_top import sptq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence requests and scans.
  sptq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (in_req_i.op),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold entries, pick the best, build responses.
  sptq_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (in_req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (out_rsp_o)
  );

endmodule
